@@ hw/rtl/flow_size_priority_tagger_defines.svh @@
// Assertion macros shared by the flow size priority tagger RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef FLOW_SIZE_PRIORITY_TAGGER_DEFINES_SVH
`define FLOW_SIZE_PRIORITY_TAGGER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked while out of reset.
`define FSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define FSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FSP_ASSERT(lbl, prop, msg)
`define FSP_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ hw/rtl/fsp_pkg.sv @@
package fsp_pkg;

  localparam int DEF_FLOW_INDEX_BITS = 10;
  localparam int DEF_MAX_PRIORITIES  = 6;
  localparam int MIN_PRIORITIES      = 2;
  localparam int NUM_THRESH          = 5;

  localparam int BYTES_W  = 16;
  localparam int COUNT_W  = 32;
  localparam int LEVEL_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [COUNT_W-1:0] RST_THRESH_0     = 32'd20000;
  localparam logic [COUNT_W-1:0] RST_THRESH_N     = 32'd0;
  localparam logic [COUNT_W-1:0] RST_CLEAR_THRESH = 32'd15000000;
  localparam logic [LEVEL_W-1:0] RST_NUM_PRIO     = 3'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_PRIO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_3   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_4   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_THR  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_HDRS = 3'd7;

  typedef struct packed {
    logic clr_step;  // zero one counter entry during the clearing pass
    logic capture;   // take a request
    logic read;      // read the flow counter
    logic sum;       // add counted bytes
    logic emit;      // classify, write back, present result
  } fsp_cmd_t;

  typedef struct packed {
    logic clr_last;  // clearing pass at the last entry
  } fsp_sts_t;

endpackage

@@ hw/rtl/fsp_ctrl.sv @@
`include "flow_size_priority_tagger_defines.svh"

module fsp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  fsp_pkg::fsp_sts_t sts,
  output fsp_pkg::fsp_cmd_t cmd,
  output logic             busy
);
  import fsp_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_SUM   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_READ;
      end
      ST_READ: state_next = ST_SUM;
      ST_SUM:  state_next = ST_EMIT;
      ST_EMIT: state_next = ST_IDLE;
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd.clr_step = (state == ST_CLEAR);
    cmd.capture  = (state == ST_IDLE) && start;
    cmd.read     = (state == ST_READ);
    cmd.sum      = (state == ST_SUM);
    cmd.emit     = (state == ST_EMIT);
  end

  assign busy = (state != ST_IDLE);

  `FSP_ASSERT(a_accept_to_emit, (cmd.capture |-> ##3 cmd.emit),
              "request did not reach write-back three cycles after accept")
  `FSP_ASSERT(a_clear_exit, ($fell(cmd.clr_step) |-> $past(sts.clr_last)),
              "clearing pass ended before the last entry")
  `FSP_ASSERT(a_no_accept_busy, (busy |-> !cmd.capture),
              "request taken while busy")
  `FSP_ASSERT_ALWAYS(a_rst_clear, (rst |=> cmd.clr_step),
                     "reset did not start the clearing pass")

endmodule

@@ hw/rtl/fsp_dp.sv @@
`include "flow_size_priority_tagger_defines.svh"

module fsp_dp #(
  parameter int FLOW_INDEX_BITS = fsp_pkg::DEF_FLOW_INDEX_BITS,
  parameter int MAX_PRIORITIES  = fsp_pkg::DEF_MAX_PRIORITIES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  fsp_pkg::fsp_cmd_t                  cmd,
  output fsp_pkg::fsp_sts_t                  sts,
  input  logic                               cfg_we,
  input  logic [fsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fsp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [FLOW_INDEX_BITS-1:0]         flow_index,
  input  logic [fsp_pkg::BYTES_W-1:0]        packet_bytes,
  input  logic [fsp_pkg::BYTES_W-1:0]        header_bytes,
  output logic                               done,
  output logic [fsp_pkg::LEVEL_W-1:0]        priority_res,
  output logic [fsp_pkg::COUNT_W-1:0]        flow_bytes,
  output logic                               counter_cleared
);
  import fsp_pkg::*;

  localparam int DEPTH = 1 << FLOW_INDEX_BITS;
  localparam logic [LEVEL_W-1:0] MAX_LVL = LEVEL_W'(MAX_PRIORITIES);
  localparam logic [LEVEL_W-1:0] MIN_LVL = LEVEL_W'(MIN_PRIORITIES);

  // configuration
  logic [LEVEL_W-1:0] num_prio;
  logic [COUNT_W-1:0] thresh [NUM_THRESH];
  logic [COUNT_W-1:0] clear_thr;
  logic               count_hdrs;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_prio   <= RST_NUM_PRIO;
      thresh[0]  <= RST_THRESH_0;
      for (int i = 1; i < NUM_THRESH; i++) thresh[i] <= RST_THRESH_N;
      clear_thr  <= RST_CLEAR_THRESH;
      count_hdrs <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_PRIO:   num_prio   <= cfg_data[LEVEL_W-1:0];
        REG_THRESH_0:   thresh[0]  <= cfg_data[COUNT_W-1:0];
        REG_THRESH_1:   thresh[1]  <= cfg_data[COUNT_W-1:0];
        REG_THRESH_2:   thresh[2]  <= cfg_data[COUNT_W-1:0];
        REG_THRESH_3:   thresh[3]  <= cfg_data[COUNT_W-1:0];
        REG_THRESH_4:   thresh[4]  <= cfg_data[COUNT_W-1:0];
        REG_CLEAR_THR:  clear_thr  <= cfg_data[COUNT_W-1:0];
        REG_COUNT_HDRS: count_hdrs <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clearing pass address
  logic [FLOW_INDEX_BITS-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign sts.clr_last = (clr_addr == FLOW_INDEX_BITS'(DEPTH - 1));

  // request capture
  logic [FLOW_INDEX_BITS-1:0] idx;
  logic [BYTES_W-1:0]         counted;
  logic [BYTES_W-1:0]         counted_next;

  always_comb begin
    if (count_hdrs) begin
      counted_next = packet_bytes;
    end else if (packet_bytes > header_bytes) begin
      counted_next = packet_bytes - header_bytes;
    end else begin
      counted_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx     <= flow_index;
      counted <= counted_next;
    end
  end

  // flow counter memory
  logic [COUNT_W-1:0] counts [DEPTH];
  logic [COUNT_W-1:0] rd_data;
  logic [COUNT_W-1:0] total;
  logic               clear_hit;

  assign clear_hit = (total >= clear_thr);

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      counts[clr_addr] <= '0;
    end else if (cmd.emit) begin
      counts[idx] <= clear_hit ? '0 : total;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) rd_data <= counts[idx];
  end

  // wraps mod 2^32
  always_ff @(posedge clk) begin
    if (cmd.sum) total <= rd_data + COUNT_W'(counted);
  end

  // level selection: first level in use whose limit is not exceeded
  logic [LEVEL_W-1:0] n_use;
  logic [LEVEL_W-1:0] last_lvl;
  logic [LEVEL_W-1:0] prio_next;

  always_comb begin
    if (num_prio < MIN_LVL) begin
      n_use = MIN_LVL;
    end else if (num_prio > MAX_LVL) begin
      n_use = MAX_LVL;
    end else begin
      n_use = num_prio;
    end
    last_lvl  = n_use - 1'b1;
    prio_next = last_lvl;
    for (int k = NUM_THRESH - 1; k >= 0; k--) begin
      if ((LEVEL_W'(k) < last_lvl) && (total <= thresh[k])) prio_next = LEVEL_W'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      priority_res    <= prio_next;
      flow_bytes      <= total;
      counter_cleared <= clear_hit;
    end
  end

  `FSP_ASSERT(a_done_after_emit, (done |-> $past(cmd.emit)),
              "result strobe without write-back")
  `FSP_ASSERT(a_clear_consistent, (done |-> (counter_cleared == (flow_bytes >= clear_thr))),
              "cleared flag disagrees with the clear threshold")
  `FSP_ASSERT(a_prio_range, (done |-> (priority_res < n_use)),
              "priority outside the levels in use")
  `FSP_ASSERT(a_clear_no_emit, (cmd.clr_step |-> !(cmd.emit || cmd.capture)),
              "request activity during the clearing pass")

endmodule

@@ hw/rtl/flow_size_priority_tagger.sv @@
// Per-flow byte counting and priority tagging. Assert start with flow_index,
// packet_bytes and header_bytes while busy is low; the request is taken at
// that edge. Exactly one result follows: done is high for one cycle, after
// the request has passed the READ, SUM and EMIT states, with priority_res,
// flow_bytes and counter_cleared valid in that cycle, and the receiver cannot
// stall it. Busy stays high from the accept through the read, add and
// write-back of the flow counter memory, which has one registered read port
// and one write port. After reset the counter memory is zeroed one entry per
// cycle, all 2^FLOW_INDEX_BITS entries (1024 at the default), with busy high;
// the config port is live during that time. Write configuration only while
// no request is outstanding.
module flow_size_priority_tagger #(
  parameter int FLOW_INDEX_BITS = fsp_pkg::DEF_FLOW_INDEX_BITS,
  parameter int MAX_PRIORITIES  = fsp_pkg::DEF_MAX_PRIORITIES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           start,
  output logic                           busy,
  input  logic [FLOW_INDEX_BITS-1:0]     flow_index,
  input  logic [fsp_pkg::BYTES_W-1:0]    packet_bytes,
  input  logic [fsp_pkg::BYTES_W-1:0]    header_bytes,
  output logic                           done,
  output logic [fsp_pkg::LEVEL_W-1:0]    priority_res,
  output logic [fsp_pkg::COUNT_W-1:0]    flow_bytes,
  output logic                           counter_cleared
);
  import fsp_pkg::*;

  fsp_cmd_t cmd;
  fsp_sts_t sts;

  fsp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  fsp_dp #(
    .FLOW_INDEX_BITS (FLOW_INDEX_BITS),
    .MAX_PRIORITIES  (MAX_PRIORITIES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .flow_index      (flow_index),
    .packet_bytes    (packet_bytes),
    .header_bytes    (header_bytes),
    .done            (done),
    .priority_res    (priority_res),
    .flow_bytes      (flow_bytes),
    .counter_cleared (counter_cleared)
  );

endmodule
